### hdl/tag_allocator_with_owner_map_macros.svh
// Assertion macros shared by the tag allocator RTL.
`ifndef TAG_ALLOCATOR_WITH_OWNER_MAP_MACROS_SVH
`define TAG_ALLOCATOR_WITH_OWNER_MAP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low
`define TAM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low
`define TAM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/tam_pkg.sv
// Types and constants for the tag allocator with owner map.
package tam_pkg;

	localparam int TagW    = 6;
	localparam int OwnerW  = 32;
	localparam int MaxTags = 64;

	typedef enum logic [1:0] {
		REQ_ALLOC       = 2'd0,
		REQ_RELEASE     = 2'd1,
		REQ_RELEASE_ALL = 2'd2,
		REQ_LOOKUP      = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_TAG    = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Owner write, sent to both owner stores
	typedef struct packed {
		logic              en;
		logic [TagW-1:0]   idx;
		logic [OwnerW-1:0] data;
	} owner_wr_t;

	// Lowest free tag from the free map
	typedef struct packed {
		logic            any_free;
		logic [TagW-1:0] idx;
	} grant_t;

endpackage

### hdl/tag_allocator_with_owner_map.sv
// Tag allocator with owner map: top level, request stage and result register.
// A request is taken into the request stage, then loads the result register, and its result
// beat is taken from there. A stalled result holds the request. Throughput: one request per
// cycle while the result is not stalled; the free-map encoder and the parallel owner compare
// sit between the request and result registers, the owner RAM read lands with the request.
// Reset: all tags free, both stages empty; owner entries hold no reset value.
module tag_allocator_with_owner_map #(
	parameter int NUM_TAGS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     req_type,
	input  logic [tam_pkg::OwnerW-1:0]     owner_id,
	input  logic [tam_pkg::TagW-1:0]       tag_in,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [tam_pkg::TagW-1:0]       tag_out,
	output logic [tam_pkg::OwnerW-1:0]     owner_out
);

	`include "tag_allocator_with_owner_map_macros.svh"

	localparam int IdxW = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
	localparam int MaxT = tam_pkg::MaxTags;

	// request stage
	logic                          valid_s1;
	tam_pkg::req_t                 req_s1;
	logic [tam_pkg::OwnerW-1:0]    owner_s1;
	logic                          byp_hit_s1;
	logic [tam_pkg::OwnerW-1:0]    byp_data_s1;

	// result register
	logic                          out_valid_q;
	tam_pkg::status_t              status_q;
	logic [tam_pkg::TagW-1:0]      tag_out_q;
	logic [tam_pkg::OwnerW-1:0]    owner_out_q;

	logic                          advance;
	logic                          in_acc;
	tam_pkg::owner_wr_t            wr;
	tam_pkg::grant_t               grant;
	logic                          tag_held;
	logic [NUM_TAGS-1:0]           free_q;
	logic [MaxT-1:0]               free_pad;
	logic [NUM_TAGS-1:0]           match;
	logic [tam_pkg::OwnerW-1:0]    ram_rdata;
	logic [tam_pkg::OwnerW-1:0]    look_data;
	logic [tam_pkg::TagW-1:0]      tag_s1;

	tam_pkg::status_t              status_nxt;
	logic [tam_pkg::TagW-1:0]      tag_nxt;
	logic [tam_pkg::OwnerW-1:0]    owner_nxt;

	// check terms
	logic [MaxT-1:0]               grant_bit;
	logic                          alloc_empty;
	logic                          refused;
	logic                          reply_clear;

	// Handshake
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_acc   = in_valid && !in_stall;
	assign free_pad = MaxT'(free_q);

	// Request stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Bypass catches an owner write to the address read on the same edge
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1      <= tam_pkg::req_t'(req_type);
			owner_s1    <= owner_id;
			tag_s1      <= tag_in;
			byp_hit_s1  <= wr.en && (wr.idx == tag_in);
			byp_data_s1 <= wr.data;
		end
	end

	// Owner write on a granted allocate
	assign wr.en   = advance && (req_s1 == tam_pkg::REQ_ALLOC) && grant.any_free;
	assign wr.idx  = grant.idx;
	assign wr.data = owner_s1;

	tam_free_map #(
		.NUM_TAGS(NUM_TAGS)
	) u_free_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (advance),
		.req      (req_s1),
		.tag      (tag_s1),
		.match    (match),
		.grant    (grant),
		.tag_held (tag_held),
		.free_q   (free_q)
	);

	tam_owner_cam #(
		.NUM_TAGS(NUM_TAGS)
	) u_owner_cam (
		.clk       (clk),
		.wr        (wr),
		.cmp_owner (owner_s1),
		.match     (match)
	);

	tam_ram #(
		.WIDTH(tam_pkg::OwnerW),
		.DEPTH(NUM_TAGS)
	) u_owner_ram (
		.clk   (clk),
		.we    (wr.en),
		.waddr (wr.idx[IdxW-1:0]),
		.wdata (wr.data),
		.re    (in_acc),
		.raddr (tag_in[IdxW-1:0]),
		.rdata (ram_rdata)
	);

	assign look_data = byp_hit_s1 ? byp_data_s1 : ram_rdata;

	// Result per request
	always_comb begin
		status_nxt = tam_pkg::ST_OK;
		tag_nxt    = '0;
		owner_nxt  = '0;
		case (req_s1)
			tam_pkg::REQ_ALLOC: begin
				if (grant.any_free) begin
					tag_nxt = grant.idx;
				end else begin
					status_nxt = tam_pkg::ST_NO_TAG;
				end
			end
			tam_pkg::REQ_LOOKUP: begin
				if (tag_held) begin
					owner_nxt = look_data;
				end else begin
					status_nxt = tam_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				status_nxt = tam_pkg::ST_OK;
			end
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q    <= status_nxt;
			tag_out_q   <= tag_nxt;
			owner_out_q <= owner_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign tag_out   = tag_out_q;
	assign owner_out = owner_out_q;

	// Terms for the checks
	assign grant_bit   = MaxT'(1) << wr.idx;
	assign alloc_empty = advance && (req_s1 == tam_pkg::REQ_ALLOC) && (free_q == '0);
	assign refused     = out_valid_q && (status_q == tam_pkg::ST_NO_TAG);
	assign reply_clear = (tag_out_q == '0) && (owner_out_q == '0);

	// Checks
	`TAM_ASSERT_NOW(a_grant_is_free, wr.en, |(free_pad & grant_bit), "granted tag not free")
	`TAM_ASSERT_NEXT(a_grant_taken, wr.en, !(|(free_pad & $past(grant_bit))), "granted tag still free")
	`TAM_ASSERT_NEXT(a_empty_refused, alloc_empty, status_q == tam_pkg::ST_NO_TAG, "empty pool granted")
	`TAM_ASSERT_NOW(a_no_tag_clean, refused, reply_clear, "refusal carries data")
	`TAM_ASSERT_NOW(a_stall_has_item, in_stall, valid_s1, "stall without held request")

endmodule

### hdl/tam_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tam_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/tam_owner_cam.sv
// Owner entries held in flops, compared against one owner id in parallel.
module tam_owner_cam #(
	parameter int NUM_TAGS = 64
) (
	input  logic                           clk,
	input  tam_pkg::owner_wr_t             wr,
	input  logic [tam_pkg::OwnerW-1:0]     cmp_owner,
	output logic [NUM_TAGS-1:0]            match
);

	logic [tam_pkg::OwnerW-1:0] entry_q [NUM_TAGS];

	// Entry write, decoded per lane
	always_ff @(posedge clk) begin
		for (int t = 0; t < NUM_TAGS; t++) begin
			if (wr.en && (wr.idx == tam_pkg::TagW'(t))) begin
				entry_q[t] <= wr.data;
			end
		end
	end

	// One comparator per entry
	always_comb begin
		for (int t = 0; t < NUM_TAGS; t++) begin
			match[t] = (entry_q[t] == cmp_owner);
		end
	end

endmodule

### hdl/tam_free_map.sv
// Free bitmap with lowest-free-tag encoder and release/release-all update.
module tam_free_map #(
	parameter int NUM_TAGS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       upd,
	input  tam_pkg::req_t              req,
	input  logic [tam_pkg::TagW-1:0]   tag,
	input  logic [NUM_TAGS-1:0]        match,
	output tam_pkg::grant_t            grant,
	output logic                       tag_held,
	output logic [NUM_TAGS-1:0]        free_q
);

	localparam int MaxT = tam_pkg::MaxTags;

	logic [MaxT-1:0]     free_pad;
	logic [MaxT-1:0]     lowest;
	logic [MaxT-1:0]     rel_pad;
	logic                tag_ok;
	logic [NUM_TAGS-1:0] free_nxt;

	assign free_pad = MaxT'(free_q);
	// Isolate the lowest set bit
	assign lowest   = free_pad & (~free_pad + MaxT'(1));
	assign tag_ok   = (int'(tag) < NUM_TAGS);
	assign rel_pad  = MaxT'(1) << tag;
	assign tag_held = tag_ok && !free_pad[tag];

	// One-hot to index: each index bit ORs the lanes that have it set
	always_comb begin
		grant.any_free = |free_q;
		grant.idx      = '0;
		for (int b = 0; b < tam_pkg::TagW; b++) begin
			for (int t = 0; t < MaxT; t++) begin
				if (((t >> b) & 1) == 1) begin
					grant.idx[b] = grant.idx[b] | lowest[t];
				end
			end
		end
	end

	// Next map per request
	always_comb begin
		free_nxt = free_q;
		case (req)
			tam_pkg::REQ_ALLOC: begin
				free_nxt = free_q & ~lowest[NUM_TAGS-1:0];
			end
			tam_pkg::REQ_RELEASE: begin
				if (tag_ok) begin
					free_nxt = free_q | rel_pad[NUM_TAGS-1:0];
				end
			end
			tam_pkg::REQ_RELEASE_ALL: begin
				// only held tags take part in the compare
				free_nxt = free_q | (match & ~free_q);
			end
			default: begin
				free_nxt = free_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q <= '1;
		end else if (upd) begin
			free_q <= free_nxt;
		end
	end

endmodule

### bench/tag_allocator_with_owner_map_test.sv
// Self-checking bench for the tag allocator: directed request table, then random traffic.
`timescale 1ns / 1ps

module tag_allocator_with_owner_map_test;
	import tam_pkg::*;

	localparam int HOLD_CYCLES = 50;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_REQS = 665;

	typedef struct packed {
		status_t           status;
		logic [TagW-1:0]   tag;
		logic [OwnerW-1:0] owner;
	} reply_t;

	typedef struct {
		req_t              req;
		logic [OwnerW-1:0] owner;
		logic [TagW-1:0]   tag;
		int                reps;
		logic              fixed;
		reply_t            want;
	} row_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [1:0]        req_type  = 2'd0;
	logic [OwnerW-1:0] owner_id  = '0;
	logic [TagW-1:0]   tag_in    = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [1:0]        status;
	logic [TagW-1:0]   tag_out;
	logic [OwnerW-1:0] owner_out;

	// typed-in expectation, travelling alongside its beat
	logic   beat_fixed = 1'b0;
	reply_t beat_want  = '0;

	// bench copy of the pool state
	logic [MaxTags-1:0] free_tags = '1;
	logic [OwnerW-1:0]  tag_owner [MaxTags];

	reply_t owed_replies [$];
	reply_t guess, seen, want;
	row_t   dir_rows [$];
	logic   took_in, took_out;
	logic   idle_on        = 1'b1;
	int     requests_taken = 0;
	int     mismatch_cnt   = 0;
	int     quiet_cycles   = 0;

	tag_allocator_with_owner_map #(
		.NUM_TAGS(MaxTags)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.owner_id (owner_id),
		.tag_in   (tag_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.tag_out  (tag_out),
		.owner_out(owner_out)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Reply the pool gives to one request; updates the bench copy of the state
	function automatic reply_t pool_reply(input req_t r, input logic [OwnerW-1:0] own,
			input logic [TagW-1:0] t);
		reply_t             res;
		logic [MaxTags-1:0] hits;
		res.status = ST_OK;
		res.tag    = '0;
		res.owner  = '0;
		hits       = '0;
		case (r)
			REQ_ALLOC: begin
				if (free_tags == '0) begin
					res.status = ST_NO_TAG;
				end else begin
					// scan downwards so the lowest free tag wins
					for (int k = MaxTags - 1; k >= 0; k--)
						if (free_tags[k]) res.tag = TagW'(k);
					free_tags[res.tag] = 1'b0;
					tag_owner[res.tag] = own;
				end
			end
			REQ_RELEASE: free_tags[t] = 1'b1;
			REQ_RELEASE_ALL: begin
				// only held tags are compared, so stale owners never match
				for (int k = 0; k < MaxTags; k++)
					if (!free_tags[k] && tag_owner[k] == own) hits[k] = 1'b1;
				free_tags |= hits;
			end
			default: begin
				if (!free_tags[t]) res.owner = tag_owner[t];
				else res.status = ST_NOT_FOUND;
			end
		endcase
		return res;
	endfunction

	task automatic add_row(input req_t r, input logic [OwnerW-1:0] own,
			input logic [TagW-1:0] t, input int reps, input logic fixed,
			input status_t st, input logic [TagW-1:0] tg, input logic [OwnerW-1:0] ow);
		row_t row;
		row.req         = r;
		row.owner       = own;
		row.tag         = t;
		row.reps        = reps;
		row.fixed       = fixed;
		row.want.status = st;
		row.want.tag    = tg;
		row.want.owner  = ow;
		dir_rows.push_back(row);
	endtask

	// Offer one request beat, with an occasional gap in front, and wait for it to be taken
	task automatic offer_request(input req_t r, input logic [OwnerW-1:0] own,
			input logic [TagW-1:0] t, input logic fixed, input reply_t fx);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= r;
		owner_id   <= own;
		tag_in     <= t;
		beat_fixed <= fixed;
		beat_want  <= fx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Monitor: predict on every request beat, check every reply beat, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			took_in  = in_valid && !in_stall;
			took_out = out_valid && !out_stall;
			if (took_out) begin
				seen.status = status_t'(status);
				seen.tag    = tag_out;
				seen.owner  = owner_out;
				if (owed_replies.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("%0t: reply with none owed: status %0d tag %0d owner %h",
							$realtime, seen.status, seen.tag, seen.owner);
				end else begin
					want = owed_replies[0];
					owed_replies.delete(0);
					if (seen.status !== want.status || seen.tag !== want.tag ||
							seen.owner !== want.owner) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10) begin
							$write("%0t: reply mismatch: expected status %0d tag %0d owner %h",
								$realtime, want.status, want.tag, want.owner);
							$display(", got status %0d tag %0d owner %h",
								seen.status, seen.tag, seen.owner);
						end
					end
				end
			end
			if (took_in) begin
				guess = pool_reply(req_t'(req_type), owner_id, tag_in);
				owed_replies.push_back(beat_fixed ? beat_want : guess);
				requests_taken++;
			end
			if (took_in || took_out) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Reply side: short random stalls, and one long hold-off to back the block up
	initial begin : rx_side
		logic held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && requests_taken >= 300) begin
				held = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Request side: directed table, then random traffic in repeating fill, mixed and drain phases
	initial begin : tx_side
		int                n, pick, a_w, r_w, ra_w;
		req_t              r;
		logic [OwnerW-1:0] own;
		logic [TagW-1:0]   t;
		logic [OwnerW-1:0] owner_pool [4];
		reply_t            none;
		owner_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h1357_9BDF, 32'h8000_0001};
		none       = '0;

		// empty pool: lookups miss, releases are harmless
		add_row(REQ_LOOKUP,      32'h0000_0000,  6'd0, 1, 1'b1, ST_NOT_FOUND, 6'd0, 32'h0);
		add_row(REQ_LOOKUP,      32'h0000_0000, 6'd63, 1, 1'b1, ST_NOT_FOUND, 6'd0, 32'h0);
		add_row(REQ_RELEASE,     32'h0000_0000,  6'd5, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_RELEASE_ALL, 32'hFFFF_FFFF,  6'd0, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		// first grants, owner extremes
		add_row(REQ_ALLOC,       32'h0000_0000, 6'd63, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_ALLOC,       32'hFFFF_FFFF,  6'd0, 1, 1'b1, ST_OK, 6'd1, 32'h0);
		add_row(REQ_LOOKUP,      32'h0000_0000,  6'd1, 1, 1'b1, ST_OK, 6'd0, 32'hFFFF_FFFF);
		add_row(REQ_LOOKUP,      32'hFFFF_FFFF,  6'd0, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		// fill the pool, then ask once more
		add_row(REQ_ALLOC,       32'h5555_5555,  6'd0, 62, 1'b0, ST_OK, 6'd0, 32'h0);
		add_row(REQ_ALLOC,       32'h1234_5678,  6'd0, 1, 1'b1, ST_NO_TAG, 6'd0, 32'h0);
		add_row(REQ_LOOKUP,      32'h0000_0000, 6'd63, 1, 1'b1, ST_OK, 6'd0, 32'h5555_5555);
		// a freed tag in the middle is the next one granted
		add_row(REQ_RELEASE,     32'h0000_0000, 6'd10, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_ALLOC,       32'hAAAA_AAAA,  6'd0, 1, 1'b1, ST_OK, 6'd10, 32'h0);
		// release-all of one owner; the stale entries must not match again
		add_row(REQ_RELEASE_ALL, 32'h5555_5555,  6'd0, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_LOOKUP,      32'h0000_0000, 6'd10, 1, 1'b1, ST_OK, 6'd0, 32'hAAAA_AAAA);
		add_row(REQ_LOOKUP,      32'h0000_0000, 6'd20, 1, 1'b1, ST_NOT_FOUND, 6'd0, 32'h0);
		add_row(REQ_RELEASE_ALL, 32'h5555_5555,  6'd0, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_ALLOC,       32'h0F0F_0F0F, 6'd33, 1, 1'b0, ST_OK, 6'd0, 32'h0);
		add_row(REQ_LOOKUP,      32'h0000_0000,  6'd2, 1, 1'b0, ST_OK, 6'd0, 32'h0);
		add_row(REQ_RELEASE_ALL, 32'h0000_0000,  6'd0, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_LOOKUP,      32'h0000_0000,  6'd0, 1, 1'b1, ST_NOT_FOUND, 6'd0, 32'h0);
		// drain what is left
		add_row(REQ_RELEASE,     32'h0000_0000,  6'd1, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_RELEASE_ALL, 32'hAAAA_AAAA,  6'd0, 1, 1'b1, ST_OK, 6'd0, 32'h0);
		add_row(REQ_RELEASE_ALL, 32'h0F0F_0F0F,  6'd0, 1, 1'b0, ST_OK, 6'd0, 32'h0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			repeat (dir_rows[i].reps)
				offer_request(dir_rows[i].req, dir_rows[i].owner, dir_rows[i].tag,
					dir_rows[i].fixed, dir_rows[i].want);

		for (n = 0; n < RANDOM_REQS; n++) begin
			// a gapless stretch mid-run, and no gaps at all near the end
			idle_on = (n < 400 || n >= 480) && n < 600;
			// let everything drain once before carrying on
			if (n == 200) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (owed_replies.size() != 0) @(posedge clk);
			end
			case ((n / 100) % 3)
				0:       begin a_w = 70; r_w = 78; ra_w = 78; end
				1:       begin a_w = 35; r_w = 60; ra_w = 72; end
				default: begin a_w = 10; r_w = 50; ra_w = 70; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < a_w) r = REQ_ALLOC;
			else if (pick < r_w) r = REQ_RELEASE;
			else if (pick < ra_w) r = REQ_RELEASE_ALL;
			else r = REQ_LOOKUP;
			// a few owners recur so release-all finds matches
			own = ($urandom_range(0, 9) < 7) ? owner_pool[$urandom_range(0, 3)] : $urandom();
			// low tags are the busy ones, since grants go lowest first
			t = ($urandom_range(0, 1) == 0) ? TagW'($urandom_range(0, 15))
				: TagW'($urandom_range(0, 63));
			offer_request(r, own, t, 1'b0, none);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_replies.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && owed_replies.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+hdl
hdl/tam_pkg.sv
hdl/tam_ram.sv
hdl/tam_owner_cam.sv
hdl/tam_free_map.sv
hdl/tag_allocator_with_owner_map.sv
bench/tag_allocator_with_owner_map_test.sv
